### design/modular_exponentiation_core_defines.svh
// Assertion macros shared by the modular exponentiation core.
// Depends on clk and rst being visible in the asserting module.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MEXP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mexp assertion failed");

// Next-cycle implication, checked outside reset.
`define MEXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mexp assertion failed");

`endif

### design/mexp_pkg.sv
// Shared widths, constants and controller/datapath interface types
// for the modular exponentiation core. No dependencies.
`default_nettype none

package mexp_pkg;

  localparam int MOD_WIDTH = 32;
  localparam int BASE_W    = 63;
  localparam int EXP_W     = 64;
  localparam int CFG_W     = 32;
  localparam int OUT_W     = 32;
  localparam int CNT_W     = $clog2(BASE_W);

  localparam logic [31:0] MOD_RESET_FULL = 32'd1000000007;
  localparam logic [MOD_WIDTH-1:0] MOD_RESET_MASKED = MOD_RESET_FULL[MOD_WIDTH-1:0];
  // A zero modulus behaves as a modulus of one.
  localparam logic [MOD_WIDTH-1:0] MOD_RESET =
    (MOD_RESET_MASKED == '0) ? MOD_WIDTH'(1) : MOD_RESET_MASKED;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_start;
    logic mul_step;
    logic mul_commit;
    logic out_load;
  } mexp_cmd_t;

  typedef struct packed {
    logic in_nonpos;
    logic exp_zero;
  } mexp_status_t;

endpackage

`default_nettype wire

### design/mexp_datapath.sv
// Datapath: modulus register, bit-serial base reduction, two bit-serial
// interleaved modular multipliers (multiply and square). Uses mexp_pkg.
`default_nettype none

module mexp_datapath
  import mexp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  input  logic [BASE_W-1:0]       base_value,
  input  logic signed [EXP_W-1:0] exponent,
  input  mexp_cmd_t               cmd,
  output mexp_status_t            status,
  output logic [OUT_W-1:0]        power_mod
);

  localparam int T_W = MOD_WIDTH + 2;

  logic [MOD_WIDTH-1:0] modulus;
  logic [MOD_WIDTH-1:0] base;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] mul_a;
  logic [MOD_WIDTH-1:0] sq_a;
  logic [MOD_WIDTH-1:0] mul_pr;
  logic [MOD_WIDTH-1:0] sq_pr;
  logic [MOD_WIDTH-1:0] result;
  logic [BASE_W-1:0]    base_sh;
  logic [EXP_W-2:0]     exp_sh;

  logic [MOD_WIDTH:0]   div_trial;
  logic [MOD_WIDTH:0]   div_diff;
  logic [MOD_WIDTH-1:0] div_next;
  logic [MOD_WIDTH-1:0] mul_pr_next;
  logic [MOD_WIDTH-1:0] sq_pr_next;
  logic [CFG_W-1:0]     cfg_masked;

  // One step of r = (2r + bit*b) mod m, with r, b < m.
  function automatic logic [MOD_WIDTH-1:0] mm_step(
    input logic [MOD_WIDTH-1:0] pr,
    input logic                 abit,
    input logic [MOD_WIDTH-1:0] b,
    input logic [MOD_WIDTH-1:0] m
  );
    logic [T_W-1:0] t;
    logic [T_W-1:0] m1;
    logic [T_W-1:0] m2;
    logic [T_W-1:0] r;
    t  = {1'b0, pr, 1'b0} + (abit ? {2'b00, b} : '0);
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (t >= m2) begin
      r = t - m2;
    end else if (t >= m1) begin
      r = t - m1;
    end else begin
      r = t;
    end
    return r[MOD_WIDTH-1:0];
  endfunction

  assign cfg_masked = cfg_wr_data & CFG_W'({MOD_WIDTH{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus <= (cfg_masked == '0) ? MOD_WIDTH'(1) : cfg_masked[MOD_WIDTH-1:0];
    end
  end

  assign div_trial   = {base, base_sh[BASE_W-1]};
  assign div_diff    = div_trial - {1'b0, modulus};
  assign div_next    = (div_trial >= {1'b0, modulus}) ? div_diff[MOD_WIDTH-1:0]
                                                      : div_trial[MOD_WIDTH-1:0];
  assign mul_pr_next = mm_step(mul_pr, mul_a[MOD_WIDTH-1], base, modulus);
  assign sq_pr_next  = mm_step(sq_pr, sq_a[MOD_WIDTH-1], base, modulus);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_sh <= base_value;
      base    <= '0;
      exp_sh  <= exponent[EXP_W-2:0];
      // Result is 1 for a non-positive exponent, else starts at 1 mod m.
      acc     <= {{(MOD_WIDTH-1){1'b0}},
                  (status.in_nonpos || (modulus != MOD_WIDTH'(1)))};
    end
    if (cmd.div_step) begin
      base    <= div_next;
      base_sh <= base_sh << 1;
    end
    if (cmd.mul_start) begin
      mul_a  <= acc;
      sq_a   <= base;
      mul_pr <= '0;
      sq_pr  <= '0;
    end
    if (cmd.mul_step) begin
      mul_pr <= mul_pr_next;
      sq_pr  <= sq_pr_next;
      mul_a  <= mul_a << 1;
      sq_a   <= sq_a << 1;
    end
    if (cmd.mul_commit) begin
      if (exp_sh[0]) begin
        acc <= mul_pr;
      end
      base   <= sq_pr;
      exp_sh <= exp_sh >> 1;
    end
    if (cmd.out_load) begin
      result <= acc;
    end
  end

  assign status.in_nonpos = exponent[EXP_W-1] || (exponent == '0);
  assign status.exp_zero  = (exp_sh == '0);
  assign power_mod        = OUT_W'(result);

endmodule

`default_nettype wire

### design/mexp_ctrl.sv
// Controller: sequences load, base reduction, exponent bit steps and the
// output register handshake. Uses mexp_pkg and the assertion macro header.
`default_nettype none
`include "modular_exponentiation_core_defines.svh"

module mexp_ctrl
  import mexp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  mexp_status_t status,
  output mexp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_MULT   = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             out_free;
  logic             in_accept;

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          count_next = '0;
          state_next = status.in_nonpos ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.div_step = 1'b1;
        count_next   = count + CNT_W'(1);
        if (count == CNT_W'(BASE_W - 1)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.exp_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          count_next    = '0;
          state_next    = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mul_step = 1'b1;
        count_next   = count + CNT_W'(1);
        if (count == CNT_W'(MOD_WIDTH - 1)) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.mul_commit = 1'b1;
        state_next     = ST_CHECK;
      end
      ST_FINISH: begin
        // Hold until the output register is free.
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MEXP_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd))
  `MEXP_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_ready)
  `MEXP_ASSERT_NEXT(a_nonpos_shortcut, in_accept && status.in_nonpos, state == ST_FINISH)
  `MEXP_ASSERT_NOW(a_load_when_free, cmd.out_load, out_free && (state == ST_FINISH))

endmodule

`default_nettype wire

### design/modular_exponentiation_core.sv
// Sequence: an exponent at or below zero goes straight to the output register;
// otherwise the base is reduced bit-serially, then each exponent bit up to the top
// set bit runs two 32-step bit-serial modular multipliers side by side and a commit
// step, and the result is then loaded. One item in flight; the output register
// lets the next item start while a result waits.
// Synchronous active-high reset restores the modulus to 1000000007 and empties the core.
`default_nettype none

module modular_exponentiation_core
  import mexp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [BASE_W-1:0]       base_value,
  input  logic signed [EXP_W-1:0] exponent,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_W-1:0]        power_mod
);

  mexp_cmd_t    cmd;
  mexp_status_t status;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .base_value  (base_value),
    .exponent    (exponent),
    .cmd         (cmd),
    .status      (status),
    .power_mod   (power_mod)
  );

endmodule

`default_nettype wire
